// File: hw/rtl/programmable_crc_byte_engine_macros.svh
// Assertion macros used by the CRC stage of the CRC engine.
`ifndef PROGRAMMABLE_CRC_BYTE_ENGINE_MACROS_SVH
`define PROGRAMMABLE_CRC_BYTE_ENGINE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PCE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define PCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pce_pkg.sv
// Types, constants and CRC step functions for the programmable CRC engine.
package pce_pkg;

  localparam int unsigned PCE_CRC_W  = 32;
  localparam int unsigned PCE_BYTE_W = 8;
  localparam int unsigned PCE_ADDR_W = 4;
  localparam int unsigned PCE_DATA_W = 32;

  // Register reset values.
  localparam logic [1:0]           PCE_RST_WIDTH_MODE = 2'd2;
  localparam logic [PCE_CRC_W-1:0] PCE_RST_POLYNOMIAL = 32'h04C1_1DB7;
  localparam logic [PCE_CRC_W-1:0] PCE_RST_INIT_VALUE = 32'hFFFF_FFFF;
  localparam logic [PCE_CRC_W-1:0] PCE_RST_FINAL_MASK = 32'hFFFF_FFFF;

  // Register indexes, taken from the word address.
  typedef enum logic [1:0] {
    REG_WIDTH_MODE = 2'd0,
    REG_POLYNOMIAL = 2'd1,
    REG_INIT_VALUE = 2'd2,
    REG_FINAL_MASK = 2'd3
  } pce_reg_e;

  // Width codes; the unused top code decodes as 32 bits.
  typedef enum logic [1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_32 = 2'd2
  } pce_width_e;

  typedef enum logic {
    CMD_BEGIN = 1'b0,
    CMD_DATA  = 1'b1
  } pce_cmd_e;

  typedef struct packed {
    logic [1:0]           width_mode;
    logic [PCE_CRC_W-1:0] polynomial;
    logic [PCE_CRC_W-1:0] init_value;
    logic [PCE_CRC_W-1:0] final_mask;
  } pce_cfg_t;

  typedef struct packed {
    logic                  command;
    logic [PCE_BYTE_W-1:0] data_byte;
  } pce_item_t;

  // Mask of the bits that belong to the selected width.
  function automatic logic [PCE_CRC_W-1:0] pce_mask(input logic [1:0] mode);
    logic [PCE_CRC_W-1:0] m;
    case (mode)
      WIDTH_8:  m = 32'h0000_00FF;
      WIDTH_16: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // One-hot mark of the top bit of the selected width.
  function automatic logic [PCE_CRC_W-1:0] pce_top(input logic [1:0] mode);
    logic [PCE_CRC_W-1:0] t;
    case (mode)
      WIDTH_8:  t = 32'h0000_0080;
      WIDTH_16: t = 32'h0000_8000;
      default:  t = 32'h8000_0000;
    endcase
    return t;
  endfunction

  // The byte placed in the top eight bits of the selected width.
  function automatic logic [PCE_CRC_W-1:0] pce_lane(input logic [1:0] mode,
                                                    input logic [PCE_BYTE_W-1:0] b);
    logic [PCE_CRC_W-1:0] l;
    case (mode)
      WIDTH_8:  l = {24'h00_0000, b};
      WIDTH_16: l = {16'h0000, b, 8'h00};
      default:  l = {b, 24'h00_0000};
    endcase
    return l;
  endfunction

  // Absorb one byte: fold it into the top, then eight shift and reduce steps.
  function automatic logic [PCE_CRC_W-1:0] pce_absorb(input logic [PCE_CRC_W-1:0] acc,
                                                      input logic [PCE_BYTE_W-1:0] b,
                                                      input logic [PCE_CRC_W-1:0] poly,
                                                      input logic [1:0] mode);
    logic [PCE_CRC_W-1:0] mask;
    logic [PCE_CRC_W-1:0] top;
    logic [PCE_CRC_W-1:0] p;
    logic [PCE_CRC_W-1:0] a;
    logic                 msb;
    mask = pce_mask(mode);
    top  = pce_top(mode);
    p    = poly & mask;
    a    = (acc & mask) ^ pce_lane(mode, b);
    for (int k = 0; k < PCE_BYTE_W; k++) begin
      msb = |(a & top);
      a   = (a << 1) & mask;
      if (msb) begin
        a = a ^ p;
      end
    end
    return a;
  endfunction

endpackage

// File: hw/rtl/pce_if.sv
// Handshake interfaces for the command words and the CRC result words.
interface pce_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface pce_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

// File: hw/rtl/programmable_crc_byte_engine.sv
// Top level of the programmable MSB-first byte-wide CRC engine.
//
//   Channel   Direction  Contents
//   in_i      in         command (begin / data), data_byte
//   out_o     out        crc_value, one word per command word
//   APB       in/out     width_mode, polynomial, init_value, final_mask
//
// A command word goes into the input register on acceptance and its CRC word
// then into the result register; one word per cycle is sustained while the
// result side takes each word. A byte's eight shift-and-reduce steps settle
// combinationally between these registers, against the accumulator.
// Reset clears the accumulator and both valid flags and restores the
// registers to a 32-bit CRC with the usual polynomial and all-ones masks.
// A stalled result word holds both stages; input is still taken while the
// input register is empty.
module programmable_crc_byte_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pce_in_if.sink                         in_i,
  pce_out_if.source                      out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pce_pkg::PCE_ADDR_W-1:0] paddr,
  input  logic [pce_pkg::PCE_DATA_W-1:0] pwdata,
  output logic [pce_pkg::PCE_DATA_W-1:0] prdata,
  output logic                           pready
);
  import pce_pkg::*;

  pce_cfg_t  cfg;
  pce_item_t item;
  logic      item_valid;
  logic      advance;

  pce_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pce_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  pce_crc_stage u_crc_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .cfg_i        (cfg),
    .advance_o    (advance),
    .out_o        (out_o)
  );

endmodule

// File: hw/rtl/pce_cfg_regs.sv
// APB register file holding width, polynomial, initial value and final mask.
module pce_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pce_pkg::PCE_ADDR_W-1:0]   paddr,
  input  logic [pce_pkg::PCE_DATA_W-1:0]   pwdata,
  output logic [pce_pkg::PCE_DATA_W-1:0]   prdata,
  output logic                             pready,
  output pce_pkg::pce_cfg_t                cfg_o
);
  import pce_pkg::*;

  pce_cfg_t cfg_q;
  pce_cfg_t cfg_d;
  logic     wr_en;
  pce_reg_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = pce_reg_e'(paddr[3:2]);

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_WIDTH_MODE: cfg_d.width_mode = pwdata[1:0];
        REG_POLYNOMIAL: cfg_d.polynomial = pwdata;
        REG_INIT_VALUE: cfg_d.init_value = pwdata;
        REG_FINAL_MASK: cfg_d.final_mask = pwdata;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_mode <= PCE_RST_WIDTH_MODE;
      cfg_q.polynomial <= PCE_RST_POLYNOMIAL;
      cfg_q.init_value <= PCE_RST_INIT_VALUE;
      cfg_q.final_mask <= PCE_RST_FINAL_MASK;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (reg_idx)
      REG_WIDTH_MODE: prdata = {30'h0, cfg_q.width_mode};
      REG_POLYNOMIAL: prdata = cfg_q.polynomial;
      REG_INIT_VALUE: prdata = cfg_q.init_value;
      REG_FINAL_MASK: prdata = cfg_q.final_mask;
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/pce_in_stage.sv
// Input register: captures one command word and holds it until the CRC stage moves on.
module pce_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  pce_in_if.sink             in_i,
  input  logic               advance_i,
  output logic               item_valid_o,
  output pce_pkg::pce_item_t item_o
);
  import pce_pkg::*;

  logic      valid_q;
  logic      valid_d;
  pce_item_t item_q;
  logic      take;

  // Room when empty or when the held word moves on this cycle.
  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.command   <= in_i.command;
      item_q.data_byte <= in_i.data_byte;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: hw/rtl/pce_crc_stage.sv
// CRC stage: updates the accumulator and registers the reported CRC word.
`include "programmable_crc_byte_engine_macros.svh"

module pce_crc_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  pce_pkg::pce_item_t item_i,
  input  pce_pkg::pce_cfg_t  cfg_i,
  output logic               advance_o,
  pce_out_if.source          out_o
);
  import pce_pkg::*;

  logic [PCE_CRC_W-1:0] acc_q;
  logic [PCE_CRC_W-1:0] acc_d;
  logic [PCE_CRC_W-1:0] crc_q;
  logic [PCE_CRC_W-1:0] crc_d;
  logic [PCE_CRC_W-1:0] mask;
  logic                 out_valid_q;
  logic                 out_valid_d;
  logic                 fire;

  // The result register frees up when empty or when its word is taken.
  assign advance_o = !out_valid_q || out_o.ready;
  assign fire      = item_valid_i && advance_o;
  assign mask      = pce_mask(cfg_i.width_mode);

  // Begin loads the initial value; data runs the eight-step byte update.
  always_comb begin
    acc_d = acc_q;
    if (fire) begin
      if (item_i.command == CMD_BEGIN) begin
        acc_d = cfg_i.init_value & mask;
      end else begin
        acc_d = pce_absorb(acc_q, item_i.data_byte, cfg_i.polynomial, cfg_i.width_mode);
      end
    end
  end

  assign crc_d = (acc_d ^ cfg_i.final_mask) & mask;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = item_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      crc_q <= crc_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.crc_value = crc_q;

  // Checks on the accumulator and result register.
  `PCE_ASSERT_NEXT(a_fire_gives_word, clk_i, rst_ni, fire, out_valid_q, "processed word not presented")
  `PCE_ASSERT_NEXT(a_begin_loads_init, clk_i, rst_ni, fire && (item_i.command == CMD_BEGIN), acc_q == ($past(cfg_i.init_value) & pce_mask($past(cfg_i.width_mode))), "begin did not load the initial value")
  `PCE_ASSERT_NEXT(a_crc_in_width, clk_i, rst_ni, fire, (crc_q & ~pce_mask($past(cfg_i.width_mode))) == '0, "CRC word has bits above the width")
  `PCE_ASSERT_NEXT(a_stall_holds_acc, clk_i, rst_ni, !advance_o, acc_q == $past(acc_q), "accumulator moved while stalled")

endmodule

// File: tb/sv/programmable_crc_byte_engine_tb.sv
// Self-checking testbench for the programmable MSB-first byte-wide CRC engine.
`timescale 1ns / 1ps

module programmable_crc_byte_engine_tb;
  import pce_pkg::*;

  // The spare width code, which the block decodes as 32 bits.
  localparam logic [1:0] WIDTH_CODE_THREE = 2'd3;
  localparam int unsigned MAX_WAIT = 14;
  localparam int unsigned LONG_HOLD = 64;
  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned PHASE_WORDS = 50;
  localparam int unsigned DIRECTED_ROWS = 32;

  // One row of the directed table: either a register write or a command word.
  typedef struct {
    bit          is_cfg;
    pce_reg_e    reg_idx;
    logic [31:0] value;
    pce_cmd_e    cmd;
    logic [7:0]  data;
    bit          fixed;
    logic [31:0] crc;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PCE_ADDR_W-1:0] paddr;
  logic [PCE_DATA_W-1:0] pwdata;
  logic [PCE_DATA_W-1:0] prdata;
  logic pready;

  pce_in_if  in_bus ();
  pce_out_if out_bus ();

  // Mirror of the block's registers and accumulator, and the CRC words still owed.
  pce_cfg_t    model_cfg;
  logic [31:0] model_acc;
  logic [31:0] expected_crc [$];
  int unsigned failures = 0;
  bit          sender_calm = 1'b0;
  bit          receiver_calm = 1'b0;
  bit          hold_request = 1'b0;
  stim_row_t   directed_rows [DIRECTED_ROWS];

  programmable_crc_byte_engine dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  // CRC width in bits; the top bit of the code alone selects 32 bits.
  function automatic int unsigned crc_width_bits(input logic [1:0] mode);
    if (mode[1]) begin
      return 32;
    end
    return (mode == WIDTH_16) ? 16 : 8;
  endfunction

  // Advance the mirrored accumulator by one command word and return the CRC word.
  function automatic logic [31:0] fold_word(input pce_item_t w);
    int unsigned bits;
    logic [31:0] msk;
    logic [31:0] poly;
    logic [31:0] acc;
    logic        carry;
    bits = crc_width_bits(model_cfg.width_mode);
    msk  = (bits == 32) ? 32'hFFFF_FFFF : ((32'h1 << bits) - 32'h1);
    poly = model_cfg.polynomial & msk;
    if (w.command == CMD_BEGIN) begin
      acc = model_cfg.init_value & msk;
    end else begin
      acc = (model_acc & msk) ^ (32'(w.data_byte) << (bits - 8));
      repeat (8) begin
        carry = acc[bits-1];
        acc   = (acc << 1) & msk;
        if (carry) begin
          acc = acc ^ poly;
        end
      end
    end
    model_acc = acc;
    return (acc ^ model_cfg.final_mask) & msk;
  endfunction

  // Pick a register value, leaning towards the extremes and the usual polynomial.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return PCE_RST_POLYNOMIAL;
      default: return $urandom;
    endcase
  endfunction

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input pce_reg_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_WIDTH_MODE: model_cfg.width_mode = value[1:0];
      REG_POLYNOMIAL: model_cfg.polynomial = value;
      REG_INIT_VALUE: model_cfg.init_value = value;
      REG_FINAL_MASK: model_cfg.final_mask = value;
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one command word after a random gap and log its CRC word once taken.
  task automatic send_word(input pce_cmd_e cmd, input logic [7:0] data,
                           input bit fixed, input logic [31:0] fixed_crc);
    int unsigned gap;
    pce_item_t   w;
    logic [31:0] predicted;
    gap = sender_calm ? 0 : $urandom_range(0, MAX_WAIT);
    repeat (gap) @(negedge clk_i) in_bus.valid <= 1'b0;
    @(negedge clk_i);
    in_bus.valid     <= 1'b1;
    in_bus.command   <= cmd;
    in_bus.data_byte <= data;
    do @(posedge clk_i); while (!in_bus.ready);
    w.command   = cmd;
    w.data_byte = data;
    predicted   = fold_word(w);
    expected_crc.push_back(fixed ? fixed_crc : predicted);
  endtask

  // Stop offering and wait until every CRC word owed has come back.
  task automatic settle();
    @(negedge clk_i) in_bus.valid <= 1'b0;
    while (expected_crc.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Stimulus: directed table, then random phases under changing settings.
  initial begin
    int unsigned phase_words;
    int unsigned msg_len;
    logic [1:0]  mode_code;
    logic [1:0]  mode_list [4];

    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_bus.valid     = 1'b0;
    in_bus.command   = CMD_BEGIN;
    in_bus.data_byte = 8'h00;
    model_cfg = '{PCE_RST_WIDTH_MODE, PCE_RST_POLYNOMIAL, PCE_RST_INIT_VALUE,
                  PCE_RST_FINAL_MASK};
    model_acc = 32'h0;
    mode_list = '{WIDTH_CODE_THREE, WIDTH_8, WIDTH_16, WIDTH_32};

    directed_rows = '{
      // Data before any begin folds into the cleared accumulator.
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'h00, 1, 32'hFFFF_FFFF},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'hFF, 0, 32'h0},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_BEGIN, 8'h00, 1, 32'h0000_0000},
      // The usual check string under the reset settings.
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'h31, 0, 32'h0},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'h32, 0, 32'h0},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'h33, 0, 32'h0},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'h34, 0, 32'h0},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'h35, 0, 32'h0},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'h36, 0, 32'h0},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'h37, 0, 32'h0},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'h38, 0, 32'h0},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'h39, 1, 32'hFC89_1918},
      // A begin ignores its data byte.
      '{0, REG_WIDTH_MODE, 32'h0, CMD_BEGIN, 8'hFF, 1, 32'h0000_0000},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'h80, 0, 32'h0},
      // 8-bit CRC; register bits above the width must be ignored.
      '{1, REG_WIDTH_MODE, 32'(WIDTH_8), CMD_BEGIN, 8'h00, 0, 32'h0},
      '{1, REG_POLYNOMIAL, 32'hFFFF_FF07, CMD_BEGIN, 8'h00, 0, 32'h0},
      '{1, REG_INIT_VALUE, 32'hABCD_EF00, CMD_BEGIN, 8'h00, 0, 32'h0},
      '{1, REG_FINAL_MASK, 32'h1234_5600, CMD_BEGIN, 8'h00, 0, 32'h0},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_BEGIN, 8'h5A, 1, 32'h0000_0000},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'h01, 1, 32'h0000_0007},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'hFF, 0, 32'h0},
      // Spare width code, widening in the middle of a message.
      '{1, REG_WIDTH_MODE, 32'(WIDTH_CODE_THREE), CMD_BEGIN, 8'h00, 0, 32'h0},
      '{1, REG_FINAL_MASK, 32'h0000_0000, CMD_BEGIN, 8'h00, 0, 32'h0},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'h00, 0, 32'h0},
      // 16-bit CRC, then narrowing in the middle of a message.
      '{1, REG_WIDTH_MODE, 32'(WIDTH_16), CMD_BEGIN, 8'h00, 0, 32'h0},
      '{1, REG_POLYNOMIAL, 32'h0000_1021, CMD_BEGIN, 8'h00, 0, 32'h0},
      '{1, REG_INIT_VALUE, 32'hFFFF_FFFF, CMD_BEGIN, 8'h00, 0, 32'h0},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_BEGIN, 8'h00, 1, 32'h0000_FFFF},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'h00, 0, 32'h0},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'hFF, 0, 32'h0},
      '{1, REG_WIDTH_MODE, 32'(WIDTH_8), CMD_BEGIN, 8'h00, 0, 32'h0},
      '{0, REG_WIDTH_MODE, 32'h0, CMD_DATA,  8'h55, 0, 32'h0}
    };

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part; registers change only once the block has drained.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_word(directed_rows[i].cmd, directed_rows[i].data,
                  directed_rows[i].fixed, directed_rows[i].crc);
      end
    end

    // Random phases: the first four walk every width code, the first two the extremes.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      settle();
      mode_code = (phase < 4) ? mode_list[phase] : 2'($urandom_range(0, 3));
      write_reg(REG_WIDTH_MODE, ($urandom & ~32'h3) | 32'(mode_code));
      write_reg(REG_POLYNOMIAL, (phase == 0) ? 32'hFFFF_FFFF :
                                (phase == 1) ? 32'h0000_0000 : pick_value());
      write_reg(REG_INIT_VALUE, (phase == 0) ? 32'h0000_0000 :
                                (phase == 1) ? 32'hFFFF_FFFF : pick_value());
      write_reg(REG_FINAL_MASK, (phase == 0) ? 32'h0000_0000 :
                                (phase == 1) ? 32'hFFFF_FFFF : pick_value());

      // In the fourth phase the receiver holds off while words keep coming.
      sender_calm   = (phase == 3) || ($urandom_range(0, 3) == 0);
      receiver_calm = (phase != 3) && ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        hold_request = 1'b1;
      end

      // Mostly whole messages, with some stray data and stray begins.
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        case ($urandom_range(0, 19))
          0: begin
            send_word(CMD_DATA, 8'($urandom), 0, 32'h0);
            phase_words++;
          end
          1: begin
            send_word(CMD_BEGIN, 8'($urandom), 0, 32'h0);
            phase_words++;
          end
          default: begin
            send_word(CMD_BEGIN, 8'($urandom), 0, 32'h0);
            msg_len = $urandom_range(0, 12);
            repeat (msg_len) send_word(CMD_DATA, 8'($urandom), 0, 32'h0);
            phase_words += msg_len + 1;
          end
        endcase
      end
    end

    settle();
    if (failures == 0) begin
      $display("programmable_crc_byte_engine_tb: PASS");
    end else begin
      $display("programmable_crc_byte_engine_tb: FAIL");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off on request, and the check.
  initial begin
    int unsigned stall;
    logic [31:0] want;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i) out_bus.ready <= 1'b0;
      end
      stall = receiver_calm ? 0 : $urandom_range(0, MAX_WAIT);
      repeat (stall) @(negedge clk_i) out_bus.ready <= 1'b0;
      @(negedge clk_i) out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      if (expected_crc.size() == 0) begin
        $error("crc_value: expected nothing, actual %08h", out_bus.crc_value);
        failures++;
      end else begin
        want = expected_crc.pop_front();
        if (out_bus.crc_value !== want) begin
          $error("crc_value: expected %08h, actual %08h", want, out_bus.crc_value);
          failures++;
        end
      end
    end
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #(2_000_000);
    $display("programmable_crc_byte_engine_tb: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pce_pkg.sv
hw/rtl/pce_if.sv
hw/rtl/pce_cfg_regs.sv
hw/rtl/pce_in_stage.sv
hw/rtl/pce_crc_stage.sv
hw/rtl/programmable_crc_byte_engine.sv
tb/sv/programmable_crc_byte_engine_tb.sv
